/* rtl/erp_pkg.sv */
// ----------------------------------------------------------------------------
// erp_pkg
// Shared widths, types, arctangent table and Q30 rounding for the point
// rotate-and-translate pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package erp_pkg;
  localparam int COORD_WIDTH   = 32;
  localparam int ANGLE_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int TURN_W        = 32;
  localparam int ZW            = TURN_W + 2;
  localparam int CS_W          = 33;
  localparam int V_W           = COORD_WIDTH + 4;
  localparam int P_W           = V_W + CS_W;
  localparam int S_W           = V_W + 1;
  localparam int NST           = CORDIC_STAGES + 8;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
  typedef logic signed [ZW-1:0]          z_t;
  typedef logic signed [CS_W-1:0]        cs_t;
  typedef logic signed [V_W-1:0]         vec_t;
  typedef logic signed [P_W-1:0]         prod_t;
  typedef logic signed [S_W-1:0]         sum_t;

  localparam cs_t INV_GAIN = 33'sd652032874;
  localparam z_t  HALF_PI  = 34'sd1073741824;
  localparam z_t  FULL_PI  = 34'sd2147483648;
  localparam sum_t C_MAX   = S_W'((64'sd1 <<< (COORD_WIDTH-1)) - 64'sd1);
  localparam sum_t C_MIN   = S_W'(-(64'sd1 <<< (COORD_WIDTH-1)));

  function automatic z_t atan_turn(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      default: t = 32'h0;
    endcase
    return z_t'({2'b00, t});
  endfunction

  // round half away from zero, then divide by 2^30
  function automatic vec_t round_q30(input prod_t p);
    logic [P_W-1:0] mag;
    logic [P_W-1:0] rnd;
    vec_t r;
    mag = p[P_W-1] ? P_W'(-p) : P_W'(p);
    rnd = mag + (P_W'(1) << 29);
    r   = vec_t'(rnd[V_W+29:30]);
    return p[P_W-1] ? -r : r;
  endfunction
endpackage
`default_nettype wire

/* rtl/erp_if.sv */
// ----------------------------------------------------------------------------
// erp_in_if / erp_out_if
// Valid/ready channels carrying one point item and one result item.
// ----------------------------------------------------------------------------
`default_nettype none
interface erp_in_if import erp_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x, point_y, point_z;
  coord_t shift_x, shift_y, shift_z;
  angle_t roll_angle, pitch_angle, yaw_angle;
  modport source (output valid, point_x, point_y, point_z, shift_x, shift_y, shift_z,
                  roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, point_x, point_y, point_z, shift_x, shift_y, shift_z,
                  roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface erp_out_if import erp_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t out_x, out_y, out_z;
  logic   saturated;
  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface
`default_nettype wire

/* rtl/erp_cordic.sv */
// ----------------------------------------------------------------------------
// erp_cordic
// Quadrant fold and pipelined rotation-mode CORDIC giving cos and sin in Q30.
// ----------------------------------------------------------------------------
`default_nettype none
module erp_cordic import erp_pkg::*; (
  input  wire logic                     clk,
  input  wire logic [CORDIC_STAGES:0]   en,
  input  wire angle_t                   angle,
  output cs_t                           cos_o,
  output cs_t                           sin_o
);
  cs_t  x_r [CORDIC_STAGES+1];
  cs_t  y_r [CORDIC_STAGES+1];
  z_t   z_r [CORDIC_STAGES+1];
  logic f_r [CORDIC_STAGES+1];
  z_t   z0;

  assign z0 = z_t'($signed({angle, {(TURN_W-ANGLE_WIDTH){1'b0}}}));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r[0] <= INV_GAIN;
      y_r[0] <= '0;
      if (z0 > HALF_PI) begin
        z_r[0] <= z0 - FULL_PI;
        f_r[0] <= 1'b1;
      end else if (z0 < -HALF_PI) begin
        z_r[0] <= z0 + FULL_PI;
        f_r[0] <= 1'b1;
      end else begin
        z_r[0] <= z0;
        f_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        f_r[i+1] <= f_r[i];
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_turn(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_turn(i);
        end
      end
    end
  end

  assign cos_o = f_r[CORDIC_STAGES] ? -x_r[CORDIC_STAGES] : x_r[CORDIC_STAGES];
  assign sin_o = f_r[CORDIC_STAGES] ? -y_r[CORDIC_STAGES] : y_r[CORDIC_STAGES];
endmodule
`default_nettype wire

/* rtl/erp_rot.sv */
// ----------------------------------------------------------------------------
// erp_rot
// Two-stage plane rotation: four registered products, then Q30 rounding
// and the sum and difference.
// ----------------------------------------------------------------------------
`default_nettype none
module erp_rot import erp_pkg::*; (
  input  wire logic clk,
  input  wire logic en_mul,
  input  wire logic en_sum,
  input  wire vec_t a,
  input  wire vec_t b,
  input  wire cs_t  c,
  input  wire cs_t  s,
  output vec_t      a_r,
  output vec_t      b_r
);
  prod_t ac_r, bs_r, as_r, bc_r;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      ac_r <= prod_t'(a) * prod_t'(c);
      bs_r <= prod_t'(b) * prod_t'(s);
      as_r <= prod_t'(a) * prod_t'(s);
      bc_r <= prod_t'(b) * prod_t'(c);
    end
    if (en_sum) begin
      a_r <= round_q30(ac_r) - round_q30(bs_r);
      b_r <= round_q30(as_r) + round_q30(bc_r);
    end
  end
endmodule
`default_nettype wire

/* rtl/euler_rotate_translate_point.sv */
// ----------------------------------------------------------------------------
// euler_rotate_translate_point
// Rotates a point by yaw, pitch then roll and adds a translation, saturated.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_ch   | sink      | point, translation, roll/pitch/yaw angles
//  out_ch  | source    | transformed point and saturated flag
//
//  One item per cycle while out_ch.ready is high; stages: fold, 16 CORDIC stages, three
//  multiply/sum rotation pairs, translate-and-clip register.
//  Each stage holds its own valid bit; an empty stage takes data even
//  when later stages stall, so bubbles close up and nothing is lost.
//  rst_n clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none
module euler_rotate_translate_point import erp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  erp_in_if.sink     in_ch,
  erp_out_if.source  out_ch
);
  localparam int CE  = CORDIC_STAGES;
  localparam int YM  = CE + 1;
  localparam int YS  = CE + 2;
  localparam int PM  = CE + 3;
  localparam int PS  = CE + 4;
  localparam int RM  = CE + 5;
  localparam int RS  = CE + 6;
  localparam int OUT = CE + 7;

  logic [NST-1:0] v_r, v_nxt;
  logic [NST:0]   en;

  coord_t pt_r [3][CE+1];
  coord_t sh_r [3][RS+1];
  cs_t    cy, sy, cp, sp, cr, sr;
  cs_t    cp_r [2], sp_r [2], cr_r [4], sr_r [4];
  vec_t   zy_r [2], xr_r [2];
  vec_t   yx, yy, pz, px, ry, rz;
  vec_t   yy_r [2];
  vec_t   yy_d;
  coord_t ox_r, oy_r, oz_r;
  logic   sat_r;
  sum_t   fx, fy, fz;

  always_comb begin
    en[NST] = out_ch.ready;
    for (int k = NST-1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    for (int k = 0; k < NST; k++) begin
      if (en[k]) begin
        v_nxt[k] = (k == 0) ? in_ch.valid : v_r[(k == 0) ? 0 : k-1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready = en[0];

  erp_cordic u_yaw   (.clk, .en(en[CE:0]), .angle(in_ch.yaw_angle),   .cos_o(cy), .sin_o(sy));
  erp_cordic u_pitch (.clk, .en(en[CE:0]), .angle(in_ch.pitch_angle), .cos_o(cp), .sin_o(sp));
  erp_cordic u_roll  (.clk, .en(en[CE:0]), .angle(in_ch.roll_angle),  .cos_o(cr), .sin_o(sr));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pt_r[0][0] <= in_ch.point_x;
      pt_r[1][0] <= in_ch.point_y;
      pt_r[2][0] <= in_ch.point_z;
      sh_r[0][0] <= in_ch.shift_x;
      sh_r[1][0] <= in_ch.shift_y;
      sh_r[2][0] <= in_ch.shift_z;
    end
    for (int k = 1; k <= CE; k++) begin
      if (en[k]) begin
        for (int j = 0; j < 3; j++) pt_r[j][k] <= pt_r[j][k-1];
      end
    end
    for (int k = 1; k <= RS; k++) begin
      if (en[k]) begin
        for (int j = 0; j < 3; j++) sh_r[j][k] <= sh_r[j][k-1];
      end
    end
    if (en[YM]) begin
      cp_r[0] <= cp; sp_r[0] <= sp; cr_r[0] <= cr; sr_r[0] <= sr;
      zy_r[0] <= vec_t'(pt_r[2][CE]);
    end
    if (en[YS]) begin
      cp_r[1] <= cp_r[0]; sp_r[1] <= sp_r[0]; cr_r[1] <= cr_r[0]; sr_r[1] <= sr_r[0];
      zy_r[1] <= zy_r[0];
    end
    for (int k = 2; k < 4; k++) begin
      if (en[YM+k]) begin
        cr_r[k] <= cr_r[k-1];
        sr_r[k] <= sr_r[k-1];
      end
    end
    if (en[RM]) xr_r[0] <= px;
    if (en[RS]) xr_r[1] <= xr_r[0];
  end

  erp_rot u_rot_yaw (.clk, .en_mul(en[YM]), .en_sum(en[YS]),
    .a(vec_t'(pt_r[0][CE])), .b(vec_t'(pt_r[1][CE])), .c(cy), .s(sy), .a_r(yx), .b_r(yy));
  erp_rot u_rot_pitch (.clk, .en_mul(en[PM]), .en_sum(en[PS]),
    .a(zy_r[1]), .b(yx), .c(cp_r[1]), .s(sp_r[1]), .a_r(pz), .b_r(px));
  erp_rot u_rot_roll (.clk, .en_mul(en[RM]), .en_sum(en[RS]),
    .a(yy_d), .b(pz), .c(cr_r[3]), .s(sr_r[3]), .a_r(ry), .b_r(rz));

  always_ff @(posedge clk) begin
    if (en[PM]) yy_r[0] <= yy;
    if (en[PS]) yy_r[1] <= yy_r[0];
  end
  assign yy_d = yy_r[1];

  assign fx = sum_t'(xr_r[1]) + sum_t'(sh_r[0][RS]);
  assign fy = sum_t'(ry)      + sum_t'(sh_r[1][RS]);
  assign fz = sum_t'(rz)      + sum_t'(sh_r[2][RS]);

  function automatic coord_t clip(input sum_t v);
    if (v > C_MAX) return coord_t'(C_MAX);
    if (v < C_MIN) return coord_t'(C_MIN);
    return coord_t'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (en[OUT]) begin
      ox_r  <= clip(fx);
      oy_r  <= clip(fy);
      oz_r  <= clip(fz);
      sat_r <= (fx > C_MAX) || (fx < C_MIN) || (fy > C_MAX) || (fy < C_MIN) ||
               (fz > C_MAX) || (fz < C_MIN);
    end
  end

  assign out_ch.valid     = v_r[OUT];
  assign out_ch.out_x     = ox_r;
  assign out_ch.out_y     = oy_r;
  assign out_ch.out_z     = oz_r;
  assign out_ch.saturated = sat_r;

`ifndef SYNTHESIS
  a_ready_when_gap: assert property (@(posedge clk) disable iff (!rst_n)
    !(&v_r) |-> in_ch.ready) else $error("input stalled with a free stage");
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en[OUT] && v_r[OUT-1] |=> v_r[OUT]) else $error("item dropped at output stage");
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |->
      (ox_r == coord_t'(C_MAX)) || (ox_r == coord_t'(C_MIN)) ||
      (oy_r == coord_t'(C_MAX)) || (oy_r == coord_t'(C_MIN)) ||
      (oz_r == coord_t'(C_MAX)) || (oz_r == coord_t'(C_MIN)))
    else $error("saturated flag without a clipped coordinate");
`endif
endmodule
`default_nettype wire
